@@ hdl/wse3_pkg.sv @@
// shared constants and types for the 3x3 window sum extremes block
package wse3_pkg;

  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_SAMPLE_BITS = 8;

  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int OUT_SUM_W  = 12;
  localparam int OUT_POS_W  = 10;
  localparam int MIN_COUNT  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } wse3_reg_t;

  // per-item flags from the front to the back
  typedef struct packed {
    logic win;   // item completes a 3x3 window
    logic last;  // last item of the frame
  } wse3_tag_t;

endpackage

@@ hdl/wse3_ram.sv @@
// generic single-write, single-read ram with registered read data
module wse3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/wse3_front.sv @@
// front end: position tracking, line stores and vertical column sums
module wse3_front import wse3_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_wdata,
  input  logic                         in_push,
  input  logic [SAMPLE_BITS-1:0]       in_sample,
  output logic                         in_full,
  output logic                         q_push,
  input  logic                         q_ready,
  output logic [SAMPLE_BITS+1:0]       q_colsum,
  output logic [$clog2(MAX_ROWS)-1:0]  q_row,
  output logic [$clog2(MAX_COLUMNS)-1:0] q_col,
  output wse3_tag_t                    q_tag
);

  localparam int CPW = $clog2(MAX_COLUMNS);
  localparam int RPW = $clog2(MAX_ROWS);
  localparam int CSW = SAMPLE_BITS + 2;

  logic [CPW-1:0]         last_col_r, last_col_nxt;
  logic [RPW-1:0]         last_row_r, last_row_nxt;
  logic [CPW-1:0]         col_r;
  logic [RPW-1:0]         row_r;
  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic [CPW-1:0]         s1_addr_r;
  logic [RPW-1:0]         s1_row_r;
  logic [CPW-1:0]         s1_col_r;
  wse3_tag_t              s1_tag_r;

  logic                   accept;
  logic                   at_last_col;
  logic                   at_last_row;
  logic [SAMPLE_BITS-1:0] up_rd;
  logic [SAMPLE_BITS-1:0] mid_rd;
  int unsigned            cfg_val;

  // clamp counts into range and keep them as last index
  always_comb begin
    cfg_val      = 32'(cfg_wdata);
    last_col_nxt = last_col_r;
    last_row_nxt = last_row_r;
    if (cfg_we) begin
      unique case (wse3_reg_t'(cfg_index))
        REG_ROW_COUNT: begin
          if (cfg_val < MIN_COUNT) begin
            last_row_nxt = RPW'(MIN_COUNT - 1);
          end else if (cfg_val > MAX_ROWS) begin
            last_row_nxt = RPW'(MAX_ROWS - 1);
          end else begin
            last_row_nxt = RPW'(cfg_val - 1);
          end
        end
        REG_COLUMN_COUNT: begin
          if (cfg_val < MIN_COUNT) begin
            last_col_nxt = CPW'(MIN_COUNT - 1);
          end else if (cfg_val > MAX_COLUMNS) begin
            last_col_nxt = CPW'(MAX_COLUMNS - 1);
          end else begin
            last_col_nxt = CPW'(cfg_val - 1);
          end
        end
      endcase
    end
  end

  assign in_full     = s1_valid_r && !q_ready;
  assign accept      = in_push && !in_full;
  assign q_push      = s1_valid_r && q_ready;
  assign at_last_col = (col_r == last_col_r);
  assign at_last_row = (row_r == last_row_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= CPW'(MIN_COUNT - 1);
      last_row_r <= RPW'(MIN_COUNT - 1);
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      last_col_r <= last_col_nxt;
      last_row_r <= last_row_nxt;
      if (cfg_we) begin
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        if (at_last_col) begin
          col_r <= '0;
          row_r <= at_last_row ? '0 : row_r + RPW'(1);
        end else begin
          col_r <= col_r + CPW'(1);
        end
      end
      s1_valid_r <= accept || (s1_valid_r && !q_push);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r   <= in_sample;
      s1_addr_r     <= col_r;
      s1_row_r      <= row_r - RPW'(2);
      s1_col_r      <= col_r - CPW'(2);
      s1_tag_r.win  <= (row_r >= RPW'(2)) && (col_r >= CPW'(2));
      s1_tag_r.last <= at_last_col && at_last_row;
    end
  end

  // the upper store takes the old middle row as the item leaves
  wse3_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_COLUMNS)) u_upper (
    .clk   (clk),
    .we    (q_push),
    .waddr (s1_addr_r),
    .wdata (mid_rd),
    .re    (accept),
    .raddr (col_r),
    .rdata (up_rd)
  );

  wse3_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_COLUMNS)) u_middle (
    .clk   (clk),
    .we    (q_push),
    .waddr (s1_addr_r),
    .wdata (s1_sample_r),
    .re    (accept),
    .raddr (col_r),
    .rdata (mid_rd)
  );

  assign q_colsum = CSW'(up_rd) + CSW'(mid_rd) + CSW'(s1_sample_r);
  assign q_row    = s1_row_r;
  assign q_col    = s1_col_r;
  assign q_tag    = s1_tag_r;

endmodule

@@ hdl/wse3_fifo.sv @@
// two-entry queue between the front and the back
module wse3_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0]           slot_r [DEPTH];
  logic                       wr_ptr_r;
  logic                       rd_ptr_r;
  logic [$clog2(DEPTH+1)-1:0] count_r;

  assign ready = (count_r != $clog2(DEPTH+1)'(DEPTH));
  assign valid = (count_r != '0);
  assign rdata = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ hdl/wse3_back.sv @@
// back end: window sums, running extremes and the result register
module wse3_back import wse3_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           restart,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  logic [SAMPLE_BITS+1:0]         q_colsum,
  input  logic [$clog2(MAX_ROWS)-1:0]    q_row,
  input  logic [$clog2(MAX_COLUMNS)-1:0] q_col,
  input  wse3_tag_t                      q_tag,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [OUT_SUM_W-1:0]           out_largest_sum,
  output logic [OUT_POS_W-1:0]           out_largest_row,
  output logic [OUT_POS_W-1:0]           out_largest_column,
  output logic [OUT_SUM_W-1:0]           out_smallest_sum,
  output logic [OUT_POS_W-1:0]           out_smallest_row,
  output logic [OUT_POS_W-1:0]           out_smallest_column
);

  localparam int CPW = $clog2(MAX_COLUMNS);
  localparam int RPW = $clog2(MAX_ROWS);
  localparam int CSW = SAMPLE_BITS + 2;
  localparam int SW  = SAMPLE_BITS + 4;

  logic [CSW-1:0] cw_old_r;
  logic [CSW-1:0] cw_new_r;
  logic           a_valid_r;
  logic [SW-1:0]  a_sum_r;
  logic [RPW-1:0] a_row_r;
  logic [CPW-1:0] a_col_r;
  wse3_tag_t      a_tag_r;
  logic           seen_r;
  logic [SW-1:0]  large_r, large_nxt;
  logic [RPW-1:0] large_row_r, large_row_nxt;
  logic [CPW-1:0] large_col_r, large_col_nxt;
  logic [SW-1:0]  small_r, small_nxt;
  logic [RPW-1:0] small_row_r, small_row_nxt;
  logic [CPW-1:0] small_col_r, small_col_nxt;
  logic           out_valid_r;
  logic [SW-1:0]  out_large_r;
  logic [RPW-1:0] out_large_row_r;
  logic [CPW-1:0] out_large_col_r;
  logic [SW-1:0]  out_small_r;
  logic [RPW-1:0] out_small_row_r;
  logic [CPW-1:0] out_small_col_r;

  logic b_ready;
  logic consume;
  logic a_ready;
  logic take_large;
  logic take_small;

  // a frame end waits only while an older result is still unread
  assign b_ready = !(a_tag_r.last && out_valid_r && !out_pop);
  assign consume = a_valid_r && b_ready;
  assign a_ready = !a_valid_r || b_ready;
  assign q_pop   = q_valid && a_ready;

  // strict compare keeps the first window in raster order
  assign take_large = a_tag_r.win && (!seen_r || (a_sum_r > large_r));
  assign take_small = a_tag_r.win && (!seen_r || (a_sum_r < small_r));

  always_comb begin
    large_nxt     = large_r;
    large_row_nxt = large_row_r;
    large_col_nxt = large_col_r;
    small_nxt     = small_r;
    small_row_nxt = small_row_r;
    small_col_nxt = small_col_r;
    if (take_large) begin
      large_nxt     = a_sum_r;
      large_row_nxt = a_row_r;
      large_col_nxt = a_col_r;
    end
    if (take_small) begin
      small_nxt     = a_sum_r;
      small_row_nxt = a_row_r;
      small_col_nxt = a_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r <= q_pop || (a_valid_r && !consume);
      if (restart) begin
        seen_r <= 1'b0;
      end else if (consume) begin
        seen_r <= a_tag_r.last ? 1'b0 : (seen_r || a_tag_r.win);
      end
      if (consume && a_tag_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_sum_r  <= SW'(cw_old_r) + SW'(cw_new_r) + SW'(q_colsum);
      a_row_r  <= q_row;
      a_col_r  <= q_col;
      a_tag_r  <= q_tag;
      cw_old_r <= cw_new_r;
      cw_new_r <= q_colsum;
    end
    if (consume) begin
      large_r     <= large_nxt;
      large_row_r <= large_row_nxt;
      large_col_r <= large_col_nxt;
      small_r     <= small_nxt;
      small_row_r <= small_row_nxt;
      small_col_r <= small_col_nxt;
    end
    if (consume && a_tag_r.last) begin
      out_large_r     <= large_nxt;
      out_large_row_r <= large_row_nxt;
      out_large_col_r <= large_col_nxt;
      out_small_r     <= small_nxt;
      out_small_row_r <= small_row_nxt;
      out_small_col_r <= small_col_nxt;
    end
  end

  assign out_empty           = !out_valid_r;
  assign out_largest_sum     = OUT_SUM_W'(out_large_r);
  assign out_largest_row     = OUT_POS_W'(out_large_row_r);
  assign out_largest_column  = OUT_POS_W'(out_large_col_r);
  assign out_smallest_sum    = OUT_SUM_W'(out_small_r);
  assign out_smallest_row    = OUT_POS_W'(out_small_row_r);
  assign out_smallest_column = OUT_POS_W'(out_small_col_r);

endmodule

@@ hdl/window_sum_extremes_3x3_core.sv @@
// top level of the 3x3 window sum extremes block
//
// Samples of a matrix frame enter row-major on the in_ queue port (push/full).
// Row and column counts are set through cfg_ (index 0 rows, index 1 columns,
// clamped to 3..MAX); a write restarts the frame and must come while idle.
// Every complete 3x3 window is summed; the largest and smallest sums are kept
// with their top-left row and column, the first in raster order winning ties.
// One result per frame leaves on the out_ queue port (empty/pop) once the
// last sample of the frame has gone through.
// Throughput: one sample per clock while in_full is low; the line stores are
// read when a sample is accepted and written when it moves on to the queue,
// on separate ports of each ram. The last sample passes the input register,
// the two-entry queue and the window sum register, then the result register.
// If the receiver does not pop, the result is held; the next frame keeps
// streaming until its own last sample reaches the result stage, then the
// back end and, through the two-entry queue, the input stall.
// Reset (synchronous, rst_n low) empties the pipeline, sets both counts to 3
// and starts a new frame; the line stores are not cleared.
module window_sum_extremes_3x3_core import wse3_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_push,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   in_full,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [OUT_SUM_W-1:0]   out_largest_sum,
  output logic [OUT_POS_W-1:0]   out_largest_row,
  output logic [OUT_POS_W-1:0]   out_largest_column,
  output logic [OUT_SUM_W-1:0]   out_smallest_sum,
  output logic [OUT_POS_W-1:0]   out_smallest_row,
  output logic [OUT_POS_W-1:0]   out_smallest_column
);

  localparam int CPW = $clog2(MAX_COLUMNS);
  localparam int RPW = $clog2(MAX_ROWS);
  localparam int CSW = SAMPLE_BITS + 2;
  localparam int QW  = CSW + RPW + CPW + $bits(wse3_tag_t);

  logic           fq_push;
  logic           fq_ready;
  logic [CSW-1:0] fq_colsum;
  logic [RPW-1:0] fq_row;
  logic [CPW-1:0] fq_col;
  wse3_tag_t      fq_tag;
  logic           bq_valid;
  logic           bq_pop;
  logic [QW-1:0]  bq_data;
  logic [CSW-1:0] bq_colsum;
  logic [RPW-1:0] bq_row;
  logic [CPW-1:0] bq_col;
  wse3_tag_t      bq_tag;

  wse3_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_sample (in_sample),
    .in_full   (in_full),
    .q_push    (fq_push),
    .q_ready   (fq_ready),
    .q_colsum  (fq_colsum),
    .q_row     (fq_row),
    .q_col     (fq_col),
    .q_tag     (fq_tag)
  );

  wse3_fifo #(.WIDTH(QW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata ({fq_colsum, fq_row, fq_col, fq_tag}),
    .ready (fq_ready),
    .pop   (bq_pop),
    .valid (bq_valid),
    .rdata (bq_data)
  );

  assign {bq_colsum, bq_row, bq_col, bq_tag} = bq_data;

  wse3_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .restart             (cfg_we),
    .q_valid             (bq_valid),
    .q_pop               (bq_pop),
    .q_colsum            (bq_colsum),
    .q_row               (bq_row),
    .q_col               (bq_col),
    .q_tag               (bq_tag),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_largest_sum     (out_largest_sum),
    .out_largest_row     (out_largest_row),
    .out_largest_column  (out_largest_column),
    .out_smallest_sum    (out_smallest_sum),
    .out_smallest_row    (out_smallest_row),
    .out_smallest_column (out_smallest_column)
  );

  // the bottom-right sample of a frame always closes a window
  a_last_is_window: assert property (@(posedge clk) disable iff (!rst_n)
    fq_push && fq_tag.last |-> fq_tag.win)
    else $error("frame end item does not complete a window");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fq_push |-> fq_ready)
    else $error("front pushed into a full queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !in_full && out_empty)
    else $error("block not idle after reset");

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for the 3x3 window sum extremes core: scoreboard against a frame model
`timescale 1ns / 1ps

module tb_top;
  import wse3_pkg::*;

  localparam int RANDOM_ITEMS  = 500;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int TALL_ROWS     = 160;
  localparam int WIDE_COLUMNS  = 160;

  typedef enum int {FILL_RANDOM, FILL_FLAT, FILL_NARROW, FILL_EXTREME} fill_kind_t;

  typedef struct packed {
    logic [OUT_SUM_W-1:0] lsum;
    logic [OUT_POS_W-1:0] lrow;
    logic [OUT_POS_W-1:0] lcol;
    logic [OUT_SUM_W-1:0] ssum;
    logic [OUT_POS_W-1:0] srow;
    logic [OUT_POS_W-1:0] scol;
  } extremes_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_push;
  logic [7:0]             in_sample;
  logic                   in_full;
  logic                   out_empty;
  logic                   out_pop;
  logic [OUT_SUM_W-1:0]   out_largest_sum;
  logic [OUT_POS_W-1:0]   out_largest_row;
  logic [OUT_POS_W-1:0]   out_largest_column;
  logic [OUT_SUM_W-1:0]   out_smallest_sum;
  logic [OUT_POS_W-1:0]   out_smallest_row;
  logic [OUT_POS_W-1:0]   out_smallest_column;

  window_sum_extremes_3x3_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_push             (in_push),
    .in_sample           (in_sample),
    .in_full             (in_full),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_largest_sum     (out_largest_sum),
    .out_largest_row     (out_largest_row),
    .out_largest_column  (out_largest_column),
    .out_smallest_sum    (out_smallest_sum),
    .out_smallest_row    (out_smallest_row),
    .out_smallest_column (out_smallest_column)
  );

  // frame model state
  logic [CFG_W-1:0]     row_cfg;
  logic [CFG_W-1:0]     col_cfg;
  logic [7:0]           upper_line [DEF_MAX_COLUMNS];
  logic [7:0]           middle_line [DEF_MAX_COLUMNS];
  logic [9:0]           col_sum [3];
  int                   next_row;
  int                   next_col;
  logic [OUT_SUM_W-1:0] hi_sum;
  logic [OUT_POS_W-1:0] hi_row;
  logic [OUT_POS_W-1:0] hi_col;
  logic [OUT_SUM_W-1:0] lo_sum;
  logic [OUT_POS_W-1:0] lo_row;
  logic [OUT_POS_W-1:0] lo_col;
  bit                   window_seen;

  extremes_t frame_results[$];
  int        fail_count;
  int        cycle_count;
  int        burst_left;
  bit        gaps_on;
  bit        hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int eff_count(logic [CFG_W-1:0] v, int top);
    if (v < MIN_COUNT) return MIN_COUNT;
    if (v > top) return top;
    return int'(v);
  endfunction

  function automatic int frame_items();
    return eff_count(row_cfg, DEF_MAX_ROWS) * eff_count(col_cfg, DEF_MAX_COLUMNS);
  endfunction

  function automatic void restart_frame();
    next_row    = 0;
    next_col    = 0;
    window_seen = 1'b0;
  endfunction

  function automatic void reset_model();
    row_cfg = CFG_W'(MIN_COUNT);
    col_cfg = CFG_W'(MIN_COUNT);
    for (int i = 0; i < DEF_MAX_COLUMNS; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 3; i++) col_sum[i] = '0;
    hi_sum = '0;
    hi_row = '0;
    hi_col = '0;
    lo_sum = '0;
    lo_row = '0;
    lo_col = '0;
    restart_frame();
  endfunction

  // updates the window state for one accepted item, queues the frame result on the last one
  function automatic void advance_window(logic [7:0] x);
    int rows;
    int cols;
    int r;
    int c;
    logic [OUT_SUM_W-1:0] win;
    extremes_t res;
    rows = eff_count(row_cfg, DEF_MAX_ROWS);
    cols = eff_count(col_cfg, DEF_MAX_COLUMNS);
    r = (next_row >= rows) ? rows - 1 : next_row;
    c = (next_col >= cols) ? cols - 1 : next_col;
    col_sum[0] = col_sum[1];
    col_sum[1] = col_sum[2];
    col_sum[2] = upper_line[c] + middle_line[c] + x;
    upper_line[c]  = middle_line[c];
    middle_line[c] = x;
    if (r >= 2 && c >= 2) begin
      win = col_sum[0] + col_sum[1] + col_sum[2];
      if (!window_seen || win > hi_sum) begin
        hi_sum = win;
        hi_row = OUT_POS_W'(r - 2);
        hi_col = OUT_POS_W'(c - 2);
      end
      if (!window_seen || win < lo_sum) begin
        lo_sum = win;
        lo_row = OUT_POS_W'(r - 2);
        lo_col = OUT_POS_W'(c - 2);
      end
      window_seen = 1'b1;
    end
    if (c + 1 < cols) begin
      next_col = c + 1;
      next_row = r;
    end else if (r + 1 < rows) begin
      next_col = 0;
      next_row = r + 1;
    end else begin
      res.lsum = hi_sum;
      res.lrow = hi_row;
      res.lcol = hi_col;
      res.ssum = lo_sum;
      res.srow = lo_row;
      res.scol = lo_col;
      frame_results.push_back(res);
      restart_frame();
    end
  endfunction

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    extremes_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (frame_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual largest %0d smallest %0d",
                 $time, out_largest_sum, out_smallest_sum);
        fail_count++;
      end else begin
        want = frame_results.pop_front();
        check_field("largest_sum", want.lsum, out_largest_sum);
        check_field("largest_row", want.lrow, out_largest_row);
        check_field("largest_column", want.lcol, out_largest_column);
        check_field("smallest_sum", want.ssum, out_smallest_sum);
        check_field("smallest_row", want.srow, out_smallest_row);
        check_field("smallest_column", want.scol, out_smallest_column);
      end
    end
  end

  // receiver: segments of steady, random and sparse popping, or a long hold when asked
  initial begin : receiver
    int seg_left;
    int seg_kind;
    bit want_pop;
    out_pop  = 1'b0;
    seg_left = 0;
    seg_kind = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_pop <= 1'b0;
        for (int held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 40);
          seg_kind = $urandom_range(0, 2);
        end
        seg_left--;
        case (seg_kind)
          0: want_pop = 1'b1;
          1: want_pop = $urandom_range(0, 1);
          default: want_pop = ($urandom_range(0, 4) == 0);
        endcase
        out_pop <= want_pop;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_sample(logic [7:0] v);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push   <= 1'b1;
    in_sample <= v;
    @(posedge clk);
    while (in_full) @(posedge clk);
    advance_window(v);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_frame(fill_kind_t fill, int count);
    logic [7:0] flat;
    logic [7:0] v;
    flat = 8'($urandom_range(0, 254));
    for (int i = 0; i < count; i++) begin
      case (fill)
        FILL_FLAT:    v = flat;
        FILL_NARROW:  v = flat + 8'($urandom_range(0, 1));
        FILL_EXTREME: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default:      v = 8'($urandom_range(0, 255));
      endcase
      send_sample(v);
    end
  endtask

  // block idle: all results in and any partial frame flushed through the pipeline
  task automatic wait_drained();
    @(negedge clk);
    in_push <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(wse3_reg_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROW_COUNT) row_cfg = val;
    else col_cfg = val;
    restart_frame();
  endtask

  function automatic logic [CFG_W-1:0] pick_count();
    if ($urandom_range(0, 9) < 8) return CFG_W'($urandom_range(3, 8));
    return CFG_W'($urandom_range(0, 20));
  endfunction

  task automatic test_reset_counts();
    // all-high and all-low frames at the reset size of 3x3
    repeat (9) send_sample(8'hFF);
    repeat (9) send_sample(8'h00);
    wait_drained();
  endtask

  task automatic test_count_clamp();
    write_reg(REG_ROW_COUNT, '0);
    write_reg(REG_COLUMN_COUNT, CFG_W'(2));
    send_frame(FILL_RANDOM, 9);
    wait_drained();
  endtask

  task automatic test_restart_on_write();
    write_reg(REG_ROW_COUNT, CFG_W'(4));
    write_reg(REG_COLUMN_COUNT, CFG_W'(4));
    send_frame(FILL_RANDOM, 5);
    wait_drained();
    // rewrite drops the partial frame
    write_reg(REG_ROW_COUNT, CFG_W'(4));
    send_frame(FILL_RANDOM, 16);
    wait_drained();
  endtask

  task automatic test_tall_frame();
    write_reg(REG_ROW_COUNT, CFG_W'(TALL_ROWS));
    write_reg(REG_COLUMN_COUNT, CFG_W'(3));
    gaps_on = 1'b0;
    // rising rows, peak window at the bottom
    for (int r = 0; r < TALL_ROWS; r++)
      for (int c = 0; c < 3; c++) send_sample(r >= TALL_ROWS - 3 ? 8'hFF : 8'(r / 5));
    gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_wide_frame();
    write_reg(REG_ROW_COUNT, CFG_W'(3));
    write_reg(REG_COLUMN_COUNT, CFG_W'(WIDE_COLUMNS));
    // falling columns, lowest window at the right edge
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < WIDE_COLUMNS; c++)
        send_sample(c >= WIDE_COLUMNS - 3 ? 8'h00 : 8'(255 - c / 5));
    wait_drained();
  endtask

  task automatic test_random_frames();
    int sent;
    int total;
    int count;
    fill_kind_t fill;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) write_reg(REG_ROW_COUNT, pick_count());
      if ($urandom_range(0, 3) != 0) write_reg(REG_COLUMN_COUNT, pick_count());
      repeat ($urandom_range(1, 3)) begin
        total = frame_items();
        // now and then a frame cut short
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total - 1) : total;
        fill  = fill_kind_t'($urandom_range(0, 3));
        send_frame(fill, count);
        sent += count;
      end
    end
    gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_output_stall();
    write_reg(REG_ROW_COUNT, CFG_W'(3));
    write_reg(REG_COLUMN_COUNT, CFG_W'(3));
    hold_req = 1'b1;
    gaps_on  = 1'b0;
    repeat (10) send_frame(FILL_RANDOM, 9);
    gaps_on = 1'b1;
    wait_drained();
  endtask

  initial begin : stimulus
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_ROW_COUNT;
    cfg_wdata  = '0;
    in_push    = 1'b0;
    in_sample  = '0;
    fail_count = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    hold_req   = 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_counts();
    test_count_clamp();
    test_restart_on_write();
    test_tall_frame();
    test_wide_frame();
    test_random_frames();
    test_output_stall();

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
